[rtl/core/nms_pkg.sv]
// nms_pkg: shared widths, types and constants of the 3x3 neighbour mean smoother.
// Used by nms_mean and neighbour_mean_smoother_3x3_unit; no dependencies.
package nms_pkg;

    localparam int SAMPLE_BITS   = 32;
    localparam int SAMPLE_PORT_W = 32;
    localparam int MAX_COLUMNS   = 1024;
    localparam int COL_W         = $clog2(MAX_COLUMNS);
    localparam int ROW_W         = 16;
    localparam int COUNT_COL_W   = 11;
    localparam int MIN_COUNT     = 2;

    localparam logic [ROW_W-1:0]       ROW_COUNT_RST = ROW_W'(2);
    localparam logic [COUNT_COL_W-1:0] COL_COUNT_RST = COUNT_COL_W'(1024);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = CFG_IDX_W'(1);

    // mean datapath
    localparam int NUM_NB      = 8;
    localparam int HALF_W      = SAMPLE_BITS + 2;
    localparam int SUM_W       = SAMPLE_BITS + 3;
    localparam int MAG_W       = SUM_W;
    localparam int RECIP_W     = MAG_W - 1;
    localparam int LO_W        = (MAG_W + 1) / 2;
    localparam int HI_W        = MAG_W - LO_W;
    localparam int PLO_W       = LO_W + RECIP_W;
    localparam int PHI_W       = HI_W + RECIP_W;
    localparam int ACC_W       = PHI_W + 1;
    localparam int DIVV_W      = 4;
    localparam int MEAN_STAGES = 8;

    // floor(2^MAG_W / d); quotient estimate is low by at most one
    localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'((64'd1 << MAG_W) / 64'd3);
    localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'((64'd1 << MAG_W) / 64'd5);
    localparam logic [RECIP_W-1:0] RECIP_8 = RECIP_W'((64'd1 << MAG_W) / 64'd8);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef enum logic [1:0] {
        DIV_3,
        DIV_5,
        DIV_8
    } t_div;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             eor;
        logic             eom;
    } t_meta;

    function automatic logic [RECIP_W-1:0] div_recip(input t_div d);
        logic [RECIP_W-1:0] r;
        unique case (d)
            DIV_3:   r = RECIP_3;
            DIV_5:   r = RECIP_5;
            default: r = RECIP_8;
        endcase
        return r;
    endfunction

    function automatic logic [DIVV_W-1:0] div_value(input t_div d);
        logic [DIVV_W-1:0] v;
        unique case (d)
            DIV_3:   v = DIVV_W'(3);
            DIV_5:   v = DIVV_W'(5);
            default: v = DIVV_W'(8);
        endcase
        return v;
    endfunction

endpackage

[rtl/core/nms_ram.sv]
// nms_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module nms_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/nms_mean.sv]
// nms_mean: eight-stage pipeline that sums up to eight masked neighbours and divides
// by 3, 5 or 8 with truncation toward zero. Depends on nms_pkg.
module nms_mean (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  nms_pkg::t_sample i_nb [0:nms_pkg::NUM_NB-1],
    input  nms_pkg::t_div    i_div,
    input  nms_pkg::t_meta   i_meta,
    output logic             o_valid,
    input  logic             i_stall,
    output nms_pkg::t_sample o_mean,
    output nms_pkg::t_meta   o_meta
);

    localparam int N = nms_pkg::MEAN_STAGES;

    logic [N:1] r_v;
    logic [N:1] ld;

    nms_pkg::t_meta r_meta [1:N];
    nms_pkg::t_div  r_div  [1:6];

    nms_pkg::t_sample                    r_p1_nb [0:nms_pkg::NUM_NB-1];
    logic signed [nms_pkg::HALF_W-1:0]   r_p2_h0;
    logic signed [nms_pkg::HALF_W-1:0]   r_p2_h1;
    logic signed [nms_pkg::SUM_W-1:0]    r_p3_sum;
    logic [nms_pkg::MAG_W-1:0]           r_p4_mag;
    logic                                r_p4_neg;
    logic [nms_pkg::PHI_W-1:0]           r_p5_hi;
    logic [nms_pkg::PLO_W-1:0]           r_p5_lo;
    logic [nms_pkg::MAG_W-1:0]           r_p5_mag;
    logic                                r_p5_neg;
    logic [nms_pkg::MAG_W-1:0]           r_p6_q0;
    logic [nms_pkg::MAG_W-1:0]           r_p6_mag;
    logic                                r_p6_neg;
    logic [nms_pkg::MAG_W-1:0]           r_p7_q;
    logic                                r_p7_neg;
    nms_pkg::t_sample                    r_p8_mean;

    logic [nms_pkg::RECIP_W-1:0] recip;
    logic [nms_pkg::ACC_W-1:0]   acc;
    logic [nms_pkg::MAG_W-1:0]   prod;
    logic [nms_pkg::MAG_W-1:0]   rem;
    logic [nms_pkg::MAG_W-1:0]   mean_full;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        ld[N] = !r_v[N] || !i_stall;
        for (int s = N - 1; s >= 1; s--) begin
            ld[s] = !r_v[s] || ld[s+1];
        end
    end

    assign o_ready = ld[1];
    assign o_valid = r_v[N];
    assign o_mean  = r_p8_mean;
    assign o_meta  = r_meta[N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ld[1]) begin
                r_v[1] <= i_valid;
            end
            for (int s = 2; s <= N; s++) begin
                if (ld[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r_meta[1] <= i_meta;
        end
        for (int s = 2; s <= N; s++) begin
            if (ld[s]) begin
                r_meta[s] <= r_meta[s-1];
            end
        end
        if (ld[1]) begin
            r_div[1] <= i_div;
        end
        for (int s = 2; s <= 6; s++) begin
            if (ld[s]) begin
                r_div[s] <= r_div[s-1];
            end
        end
    end

    assign recip = nms_pkg::div_recip(r_div[4]);
    assign acc   = nms_pkg::ACC_W'(r_p5_hi) + nms_pkg::ACC_W'(r_p5_lo >> nms_pkg::LO_W);

    always_comb begin
        unique case (r_div[6])
            nms_pkg::DIV_3: prod = r_p6_q0 + (r_p6_q0 << 1);
            nms_pkg::DIV_5: prod = r_p6_q0 + (r_p6_q0 << 2);
            default:        prod = r_p6_q0 << 3;
        endcase
        rem       = r_p6_mag - prod;
        mean_full = r_p7_neg ? -r_p7_q : r_p7_q;
    end

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r_p1_nb <= i_nb;
        end
        if (ld[2]) begin
            r_p2_h0 <= nms_pkg::HALF_W'(r_p1_nb[0]) + nms_pkg::HALF_W'(r_p1_nb[1])
                     + nms_pkg::HALF_W'(r_p1_nb[2]) + nms_pkg::HALF_W'(r_p1_nb[3]);
            r_p2_h1 <= nms_pkg::HALF_W'(r_p1_nb[4]) + nms_pkg::HALF_W'(r_p1_nb[5])
                     + nms_pkg::HALF_W'(r_p1_nb[6]) + nms_pkg::HALF_W'(r_p1_nb[7]);
        end
        if (ld[3]) begin
            r_p3_sum <= nms_pkg::SUM_W'(r_p2_h0) + nms_pkg::SUM_W'(r_p2_h1);
        end
        if (ld[4]) begin
            r_p4_neg <= r_p3_sum[nms_pkg::SUM_W-1];
            r_p4_mag <= r_p3_sum[nms_pkg::SUM_W-1] ? nms_pkg::MAG_W'(-r_p3_sum)
                                                   : nms_pkg::MAG_W'(r_p3_sum);
        end
        // magnitude times reciprocal, split in two partial products
        if (ld[5]) begin
            r_p5_lo  <= nms_pkg::PLO_W'(r_p4_mag[nms_pkg::LO_W-1:0]) * nms_pkg::PLO_W'(recip);
            r_p5_hi  <= nms_pkg::PHI_W'(r_p4_mag[nms_pkg::MAG_W-1:nms_pkg::LO_W])
                      * nms_pkg::PHI_W'(recip);
            r_p5_mag <= r_p4_mag;
            r_p5_neg <= r_p4_neg;
        end
        if (ld[6]) begin
            r_p6_q0  <= acc[nms_pkg::ACC_W-1:nms_pkg::HI_W];
            r_p6_mag <= r_p5_mag;
            r_p6_neg <= r_p5_neg;
        end
        // estimate may be one short
        if (ld[7]) begin
            r_p7_q   <= r_p6_q0 + nms_pkg::MAG_W'(rem >= nms_pkg::MAG_W'(
                            nms_pkg::div_value(r_div[6])));
            r_p7_neg <= r_p6_neg;
        end
        if (ld[8]) begin
            r_p8_mean <= nms_pkg::t_sample'(mean_full[nms_pkg::SAMPLE_BITS-1:0]);
        end
    end

endmodule

[rtl/core/neighbour_mean_smoother_3x3_unit.sv]
// neighbour_mean_smoother_3x3_unit: mean of the up to eight neighbours of each matrix position.
// Path: an input passes the input register, the window stage and the single nms_mean pipeline.
// Throughput: one input per cycle unless stalled; an input releasing n results holds the window
// stage until the mean pipeline takes all n (two on the last row, up to four at the last column).
// Reset: synchronous, active low; clears handshake state, position, and sets 2 rows x 1024 columns.
// Line RAM is not cleared. Depends on nms_pkg, nms_ram, nms_mean.
module neighbour_mean_smoother_3x3_unit (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic signed [nms_pkg::SAMPLE_PORT_W-1:0] i_sample,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic signed [nms_pkg::SAMPLE_PORT_W-1:0] o_smoothed,
    output logic [nms_pkg::ROW_W-1:0]                o_out_row,
    output logic [nms_pkg::COL_W-1:0]                o_out_column,
    output logic                                     o_end_of_run,
    output logic                                     o_end_of_matrix,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [nms_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [nms_pkg::CFG_DATA_W-1:0]           i_cfg_data
);

    localparam int SB = nms_pkg::SAMPLE_BITS;

    logic [nms_pkg::ROW_W-1:0]       r_row_count;
    logic [nms_pkg::COUNT_COL_W-1:0] r_col_count;
    logic [nms_pkg::ROW_W-1:0]       last_row;
    logic [nms_pkg::COL_W-1:0]       last_col;
    logic [nms_pkg::ROW_W-1:0]       r_row;
    logic [nms_pkg::COL_W-1:0]       r_col;

    logic                      in_accept;
    logic                      r_s1_valid;
    nms_pkg::t_sample          r_s1_sample;
    logic [nms_pkg::ROW_W-1:0] r_s1_row;
    logic [nms_pkg::COL_W-1:0] r_s1_col;
    logic                      s1_adv;

    logic [2*SB-1:0]  ram_rd_data;
    nms_pkg::t_sample line_old;
    nms_pkg::t_sample line_new;

    nms_pkg::t_sample          r_win [0:2][0:2];
    logic [nms_pkg::ROW_W-1:0] r_w_row;
    logic [nms_pkg::COL_W-1:0] r_w_col;
    logic [3:0]                r_w_mask;
    logic [3:0]                load_mask;
    logic [3:0]                w_mask_next;
    logic [1:0]                w_sel;
    logic                      w_emit;
    logic                      w_load_ok;

    logic [nms_pkg::ROW_W-1:0] ar;
    logic [nms_pkg::COL_W-1:0] ac;
    logic                      top_ok;
    logic                      bot_ok;
    logic                      left_ok;
    logic                      right_ok;
    nms_pkg::t_sample          pad [0:3][0:3];
    nms_pkg::t_sample          nb  [0:nms_pkg::NUM_NB-1];
    nms_pkg::t_div             div;
    nms_pkg::t_meta            meta;

    logic             mean_ready;
    nms_pkg::t_sample mean_out;
    nms_pkg::t_meta   out_meta;

    // effective frame size, counts below two, and column counts above the line depth, are clamped
    always_comb begin
        if (r_row_count < nms_pkg::ROW_W'(nms_pkg::MIN_COUNT)) begin
            last_row = nms_pkg::ROW_W'(nms_pkg::MIN_COUNT - 1);
        end else begin
            last_row = r_row_count - nms_pkg::ROW_W'(1);
        end
        if (r_col_count < nms_pkg::COUNT_COL_W'(nms_pkg::MIN_COUNT)) begin
            last_col = nms_pkg::COL_W'(nms_pkg::MIN_COUNT - 1);
        end else if (r_col_count > nms_pkg::COUNT_COL_W'(nms_pkg::MAX_COLUMNS)) begin
            last_col = nms_pkg::COL_W'(nms_pkg::MAX_COLUMNS - 1);
        end else begin
            last_col = nms_pkg::COL_W'(r_col_count - nms_pkg::COUNT_COL_W'(1));
        end
    end

    assign o_cfg_ready = 1'b1;
    assign w_load_ok   = (r_w_mask == '0) || (w_emit && (w_mask_next == '0));
    assign s1_adv      = r_s1_valid && w_load_ok;
    assign o_in_stall  = r_s1_valid && !w_load_ok;
    assign in_accept   = i_in_valid && !o_in_stall;

    // config and frame position; a write to the row or column count restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= nms_pkg::ROW_COUNT_RST;
            r_col_count <= nms_pkg::COL_COUNT_RST;
            r_row       <= '0;
            r_col       <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nms_pkg::CFG_ROW_COUNT: begin
                    r_row_count <= i_cfg_data[nms_pkg::ROW_W-1:0];
                    r_row       <= '0;
                    r_col       <= '0;
                end
                nms_pkg::CFG_COLUMN_COUNT: begin
                    r_col_count <= i_cfg_data[nms_pkg::COUNT_COL_W-1:0];
                    r_row       <= '0;
                    r_col       <= '0;
                end
                default: begin
                end
            endcase
        end else if (in_accept) begin
            if (r_col == last_col) begin
                r_col <= '0;
                r_row <= (r_row == last_row) ? '0 : r_row + nms_pkg::ROW_W'(1);
            end else begin
                r_col <= r_col + nms_pkg::COL_W'(1);
            end
        end
    end

    // input register; line RAM read issued on the same transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_sample <= nms_pkg::t_sample'(i_sample[SB-1:0]);
            r_s1_row    <= r_row;
            r_s1_col    <= r_col;
        end
    end

    // each entry holds {two rows up, one row up} for its column
    nms_ram #(
        .WIDTH (2 * SB),
        .DEPTH (nms_pkg::MAX_COLUMNS)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({line_new, r_s1_sample}),
        .i_rd_en   (in_accept),
        .i_rd_addr (r_col),
        .o_rd_data (ram_rd_data)
    );

    assign line_old = nms_pkg::t_sample'(ram_rd_data[2*SB-1:SB]);
    assign line_new = nms_pkg::t_sample'(ram_rd_data[SB-1:0]);

    // results released by the item at (row, col); bit = {centre on this row, centre on this col}
    always_comb begin
        load_mask[0] = (r_s1_row != '0) && (r_s1_col != '0);
        load_mask[1] = (r_s1_row != '0) && (r_s1_col == last_col);
        load_mask[2] = (r_s1_row == last_row) && (r_s1_col != '0);
        load_mask[3] = (r_s1_row == last_row) && (r_s1_col == last_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_mask <= '0;
        end else if (s1_adv) begin
            r_w_mask <= load_mask;
        end else if (w_emit) begin
            r_w_mask <= w_mask_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= line_old;
            r_win[1][2] <= line_new;
            r_win[2][2] <= r_s1_sample;
            r_w_row     <= r_s1_row;
            r_w_col     <= r_s1_col;
        end
    end

    always_comb begin
        priority if (r_w_mask[0]) begin
            w_sel = 2'd0;
        end else if (r_w_mask[1]) begin
            w_sel = 2'd1;
        end else if (r_w_mask[2]) begin
            w_sel = 2'd2;
        end else begin
            w_sel = 2'd3;
        end
    end

    assign w_mask_next = r_w_mask & ~(4'b0001 << w_sel);
    assign w_emit      = (r_w_mask != '0) && mean_ready;

    assign ar       = r_w_row - nms_pkg::ROW_W'(!w_sel[1]);
    assign ac       = r_w_col - nms_pkg::COL_W'(!w_sel[0]);
    assign top_ok   = (ar != '0);
    assign bot_ok   = (ar != last_row);
    assign left_ok  = (ac != '0);
    assign right_ok = (ac != last_col);

    // neighbours of the selected centre; outside the frame they count as zero
    always_comb begin
        int  k;
        logic ok;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                pad[i][j] = '0;
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                pad[i][j] = r_win[i][j];
            end
        end
        k = 0;
        for (int di = 0; di < 3; di++) begin
            for (int dj = 0; dj < 3; dj++) begin
                if (!(di == 1 && dj == 1)) begin
                    ok = (di != 0 || top_ok) && (di != 2 || bot_ok)
                      && (dj != 0 || left_ok) && (dj != 2 || right_ok);
                    nb[k] = ok ? pad[2'({1'b0, w_sel[1]} + 2'(di))][2'({1'b0, w_sel[0]} + 2'(dj))]
                               : '0;
                    k = k + 1;
                end
            end
        end
    end

    always_comb begin
        priority if (top_ok && bot_ok && left_ok && right_ok) begin
            div = nms_pkg::DIV_8;
        end else if ((top_ok && bot_ok) || (left_ok && right_ok)) begin
            div = nms_pkg::DIV_5;
        end else begin
            div = nms_pkg::DIV_3;
        end
        meta.row = ar;
        meta.col = ac;
        meta.eor = (w_mask_next == '0);
        meta.eom = w_sel[1] && w_sel[0];
    end

    nms_mean u_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_w_mask != '0),
        .o_ready (mean_ready),
        .i_nb    (nb),
        .i_div   (div),
        .i_meta  (meta),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_mean  (mean_out),
        .o_meta  (out_meta)
    );

    assign o_smoothed      = nms_pkg::SAMPLE_PORT_W'(mean_out);
    assign o_out_row       = out_meta.row;
    assign o_out_column    = out_meta.col;
    assign o_end_of_run    = out_meta.eor;
    assign o_end_of_matrix = out_meta.eom;

endmodule
